// ===== hw/rtl/erast_pkg.sv =====
// Shared types, widths and codes for the ellipse rasterizer.
package erast_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = 12;
  localparam int RAD_BITS   = SIZE_BITS - 1;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int X_BITS     = 12;
  localparam int Y_BITS     = 13;
  localparam int D_BITS     = 48;
  localparam int OP_BITS    = 24;
  localparam int TERM_BITS  = 14;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_SPAN  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_REG1 = 2'd1,
    PH_REG2 = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_S1, ST_S2, ST_S3, ST_S4,
    ST_C1, ST_C2, ST_C3,
    ST_EMIT,
    ST_U1, ST_U2, ST_U3,
    ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6, ST_W7, ST_W8,
    ST_R2CHK, ST_R2U1, ST_R2U2, ST_R2U3,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RYSQ_X,
    MUL_RXSQ_Y,
    MUL_RYSQ_2X3,
    MUL_RYSQ_2X2,
    MUL_RXSQ_2Y2,
    MUL_RXSQ_2Y3,
    MUL_X_X1,
    MUL_YM_YM,
    MUL_RYSQ_T,
    MUL_RXSQ_T,
    MUL_RXSQ_RYSQ
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_T,
    ACC_ADD,
    ACC_SUB,
    ACC_LOAD,
    ACC_RXSQ,
    ACC_RYSQ,
    ACC_DINIT
  } acc_op_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     inc_x;
    logic     dec_y;
    logic     out_load;
    logic     out_done;
    logic [1:0] slot;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic       lt;
    logic       d_neg;
    logic       y_neg;
    logic       fill;
    logic [3:0] present;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/ellipse_rasterizer_unit.sv =====
// Midpoint ellipse rasterizer: one request in flight, results on a registered stream.
// A start request loads the box and sets up the squared radii and the decision. A region
// 1 or region 2 advance updates the decision, with one more multiply in region 1 when
// the decision is not negative and in region 2 when it is negative, and emits the mirror
// slots one at a time (slots dropped on an axis are still examined, and a busy output
// register holds the slot). A fill advance in region 1 where y holds gives no result. The
// advance that switches regions first runs the compare and the region 2 setup. A finishing
// advance emits the done result, waiting for the output register if it is busy. All cost
// comes from one shared 24x24 multiplier whose product is registered before it feeds the
// decision accumulator. The output register can be reloaded while its result is taken.
module ellipse_rasterizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // box_left, box_top, box_width, box_height, fill_mode, zeros
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pos_x, pos_y, span_end_x
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  erast_pkg::dp_cmd_t cmd;
  erast_pkg::dp_sts_t sts;

  erast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  erast_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .box_left   (in_tdata[15:0]),
    .box_top    (in_tdata[31:16]),
    .box_width  (in_tdata[43:32]),
    .box_height (in_tdata[55:44]),
    .fill_mode  (in_tdata[56]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/erast_dp.sv =====
// Datapath: ellipse state, shared multiplier, decision accumulator, result register.
module erast_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  erast_pkg::dp_cmd_t                   cmd,
  output erast_pkg::dp_sts_t                   sts,
  input  logic [erast_pkg::COORD_BITS-1:0]     box_left,
  input  logic [erast_pkg::COORD_BITS-1:0]     box_top,
  input  logic [erast_pkg::SIZE_BITS-1:0]      box_width,
  input  logic [erast_pkg::SIZE_BITS-1:0]      box_height,
  input  logic                                 fill_mode,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [3*erast_pkg::COORD_BITS-1:0]   out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);

  localparam int CB = erast_pkg::COORD_BITS;

  logic [erast_pkg::RAD_BITS-1:0]  rad_x_r, rad_y_r;
  logic [erast_pkg::SQ_BITS-1:0]   rxsq_r, rysq_r;
  logic [CB-1:0]                   cx_r, cy_r;
  logic                            fill_r;
  logic [erast_pkg::X_BITS-1:0]    x_r;
  logic signed [erast_pkg::Y_BITS-1:0] y_r;
  logic [erast_pkg::D_BITS-1:0]    d_r, t_r, p_r;

  logic                            out_valid_r;
  erast_pkg::kind_t                out_kind_r;
  logic [CB-1:0]                   out_x_r, out_y_r, out_e_r;
  logic                            out_last_r;

  logic [erast_pkg::OP_BITS-1:0]   op_a, op_b;
  logic [erast_pkg::TERM_BITS-1:0] x2p3, x2p2, y2p2, y2p3;
  logic [erast_pkg::X_BITS-1:0]    y_mag, ym_mag;
  logic [CB-1:0]                   lx, rx, up, dn, y_ext;
  logic                            xnz, ynz;
  erast_pkg::kind_t                slot_kind;
  logic [CB-1:0]                   slot_x, slot_y, slot_e;

  assign y_mag  = y_r[erast_pkg::X_BITS-1:0];
  assign ym_mag = (y_r == '0) ? erast_pkg::X_BITS'(1) : y_mag - erast_pkg::X_BITS'(1);
  assign x2p3 = {1'b0, x_r, 1'b1} + erast_pkg::TERM_BITS'(2);
  assign x2p2 = {1'b0, x_r, 1'b0} + erast_pkg::TERM_BITS'(2);
  assign y2p2 = {1'b0, y_mag, 1'b0} + erast_pkg::TERM_BITS'(2);
  assign y2p3 = {1'b0, y_mag, 1'b1} + erast_pkg::TERM_BITS'(2);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      erast_pkg::MUL_RX_RX: begin
        op_a = erast_pkg::OP_BITS'(rad_x_r);
        op_b = erast_pkg::OP_BITS'(rad_x_r);
      end
      erast_pkg::MUL_RY_RY: begin
        op_a = erast_pkg::OP_BITS'(rad_y_r);
        op_b = erast_pkg::OP_BITS'(rad_y_r);
      end
      erast_pkg::MUL_RYSQ_X: begin
        op_a = erast_pkg::OP_BITS'(rysq_r);
        op_b = erast_pkg::OP_BITS'(x_r);
      end
      erast_pkg::MUL_RXSQ_Y: begin
        op_a = erast_pkg::OP_BITS'(rxsq_r);
        op_b = erast_pkg::OP_BITS'(y_mag);
      end
      erast_pkg::MUL_RYSQ_2X3: begin
        op_a = erast_pkg::OP_BITS'(rysq_r);
        op_b = erast_pkg::OP_BITS'(x2p3);
      end
      erast_pkg::MUL_RYSQ_2X2: begin
        op_a = erast_pkg::OP_BITS'(rysq_r);
        op_b = erast_pkg::OP_BITS'(x2p2);
      end
      erast_pkg::MUL_RXSQ_2Y2: begin
        op_a = erast_pkg::OP_BITS'(rxsq_r);
        op_b = erast_pkg::OP_BITS'(y2p2);
      end
      erast_pkg::MUL_RXSQ_2Y3: begin
        op_a = erast_pkg::OP_BITS'(rxsq_r);
        op_b = erast_pkg::OP_BITS'(y2p3);
      end
      erast_pkg::MUL_X_X1: begin
        op_a = erast_pkg::OP_BITS'(x_r);
        op_b = erast_pkg::OP_BITS'({1'b0, x_r} + 13'd1);
      end
      erast_pkg::MUL_YM_YM: begin
        op_a = erast_pkg::OP_BITS'(ym_mag);
        op_b = erast_pkg::OP_BITS'(ym_mag);
      end
      erast_pkg::MUL_RYSQ_T: begin
        op_a = erast_pkg::OP_BITS'(rysq_r);
        op_b = t_r[erast_pkg::OP_BITS-1:0];
      end
      erast_pkg::MUL_RXSQ_T: begin
        op_a = erast_pkg::OP_BITS'(rxsq_r);
        op_b = t_r[erast_pkg::OP_BITS-1:0];
      end
      erast_pkg::MUL_RXSQ_RYSQ: begin
        op_a = erast_pkg::OP_BITS'(rxsq_r);
        op_b = erast_pkg::OP_BITS'(rysq_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Product register, then ellipse state updates.
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != erast_pkg::MUL_NONE) begin
      p_r <= erast_pkg::D_BITS'(op_a * op_b);
    end
    case (cmd.acc_op)
      erast_pkg::ACC_T:     t_r    <= p_r;
      erast_pkg::ACC_ADD:   d_r    <= d_r + p_r;
      erast_pkg::ACC_SUB:   d_r    <= d_r - p_r;
      erast_pkg::ACC_LOAD:  d_r    <= p_r;
      erast_pkg::ACC_RXSQ:  rxsq_r <= p_r[erast_pkg::SQ_BITS-1:0];
      erast_pkg::ACC_RYSQ:  rysq_r <= p_r[erast_pkg::SQ_BITS-1:0];
      erast_pkg::ACC_DINIT: d_r    <= erast_pkg::D_BITS'(rysq_r) + erast_pkg::D_BITS'(rxsq_r)
                                      - p_r;
      default: ;
    endcase
    if (cmd.start) begin
      rad_x_r <= box_width[erast_pkg::SIZE_BITS-1:1];
      rad_y_r <= box_height[erast_pkg::SIZE_BITS-1:1];
      cx_r    <= box_left + CB'(box_width[erast_pkg::SIZE_BITS-1:1]);
      cy_r    <= box_top + CB'(box_height[erast_pkg::SIZE_BITS-1:1]);
      fill_r  <= fill_mode;
      x_r     <= '0;
      y_r     <= erast_pkg::Y_BITS'(box_height[erast_pkg::SIZE_BITS-1:1]);
    end else begin
      if (cmd.inc_x) x_r <= x_r + erast_pkg::X_BITS'(1);
      if (cmd.dec_y) y_r <= y_r - erast_pkg::Y_BITS'(1);
    end
  end

  // Mirrored coordinates; only the low COORD_BITS bits are kept.
  assign y_ext = CB'(y_r);
  assign lx = cx_r - CB'(x_r);
  assign rx = cx_r + CB'(x_r);
  assign up = cy_r - y_ext;
  assign dn = cy_r + y_ext;
  assign xnz = (x_r != '0);
  assign ynz = (y_r != '0);

  always_comb begin
    slot_kind = fill_r ? erast_pkg::KIND_SPAN : erast_pkg::KIND_PIXEL;
    slot_x = lx;
    slot_y = up;
    slot_e = lx;
    case (cmd.slot)
      2'd0: begin
        slot_x = lx; slot_y = up; slot_e = fill_r ? rx : lx;
      end
      2'd1: begin
        slot_x = fill_r ? lx : rx;
        slot_y = fill_r ? dn : up;
        slot_e = rx;
      end
      2'd2: begin
        slot_x = lx; slot_y = dn; slot_e = lx;
      end
      2'd3: begin
        slot_x = rx; slot_y = dn; slot_e = rx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      if (cmd.out_done) begin
        out_kind_r <= erast_pkg::KIND_DONE;
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_e_r    <= '0;
      end else begin
        out_kind_r <= slot_kind;
        out_x_r    <= slot_x;
        out_y_r    <= slot_y;
        out_e_r    <= slot_e;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_e_r, out_y_r, out_x_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign sts.lt       = (t_r < p_r);
  assign sts.d_neg    = d_r[erast_pkg::D_BITS-1];
  assign sts.y_neg    = y_r[erast_pkg::Y_BITS-1];
  assign sts.fill     = fill_r;
  assign sts.present  = fill_r ? {2'b00, ynz, 1'b1} : {xnz & ynz, ynz, xnz, 1'b1};
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

// ===== hw/rtl/erast_ctrl.sv =====
// Controller: sequences the shared multiplier, the point emission and the phases.
module erast_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_cmd,
  input  erast_pkg::dp_sts_t sts,
  output erast_pkg::dp_cmd_t cmd
);

  erast_pkg::state_t state_r, state_nxt;
  erast_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              neg_r, neg_nxt;
  logic              ret_r, ret_nxt;
  logic              accept;
  logic [3:0]        above;
  logic              slot_last;

  assign accept    = in_tvalid && in_tready;
  assign above     = sts.present & ~((4'b0010 << k_r) - 4'b0001);
  assign slot_last = (above == 4'b0000);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    neg_nxt   = neg_r;
    ret_nxt   = ret_r;
    case (state_r)
      erast_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_cmd) begin
            state_nxt = erast_pkg::ST_S1;
            phase_nxt = erast_pkg::PH_REG1;
          end else begin
            case (phase_r)
              erast_pkg::PH_REG1: state_nxt = erast_pkg::ST_C1;
              erast_pkg::PH_REG2: state_nxt = erast_pkg::ST_R2CHK;
              default:            state_nxt = erast_pkg::ST_FIN;
            endcase
          end
        end
      end
      erast_pkg::ST_S1: state_nxt = erast_pkg::ST_S2;
      erast_pkg::ST_S2: state_nxt = erast_pkg::ST_S3;
      erast_pkg::ST_S3: state_nxt = erast_pkg::ST_S4;
      erast_pkg::ST_S4: state_nxt = erast_pkg::ST_IDLE;
      erast_pkg::ST_C1: state_nxt = erast_pkg::ST_C2;
      erast_pkg::ST_C2: state_nxt = erast_pkg::ST_C3;
      erast_pkg::ST_C3: begin
        if (sts.lt) begin
          neg_nxt = sts.d_neg;
          ret_nxt = 1'b0;
          k_nxt   = 2'd0;
          // Fill skips region 1 rows where y holds.
          state_nxt = (sts.d_neg && sts.fill) ? erast_pkg::ST_U1 : erast_pkg::ST_EMIT;
        end else begin
          state_nxt = erast_pkg::ST_W1;
        end
      end
      erast_pkg::ST_EMIT: begin
        if (!sts.present[k_r]) begin
          k_nxt = k_r + 2'd1;
        end else if (sts.out_free) begin
          k_nxt = k_r + 2'd1;
          if (slot_last) begin
            state_nxt = ret_r ? erast_pkg::ST_R2U1 : erast_pkg::ST_U1;
          end
        end
      end
      erast_pkg::ST_U1: state_nxt = erast_pkg::ST_U2;
      erast_pkg::ST_U2: state_nxt = neg_r ? erast_pkg::ST_IDLE : erast_pkg::ST_U3;
      erast_pkg::ST_U3: state_nxt = erast_pkg::ST_IDLE;
      erast_pkg::ST_W1: state_nxt = erast_pkg::ST_W2;
      erast_pkg::ST_W2: state_nxt = erast_pkg::ST_W3;
      erast_pkg::ST_W3: state_nxt = erast_pkg::ST_W4;
      erast_pkg::ST_W4: state_nxt = erast_pkg::ST_W5;
      erast_pkg::ST_W5: state_nxt = erast_pkg::ST_W6;
      erast_pkg::ST_W6: state_nxt = erast_pkg::ST_W7;
      erast_pkg::ST_W7: state_nxt = erast_pkg::ST_W8;
      erast_pkg::ST_W8: begin
        state_nxt = erast_pkg::ST_R2CHK;
        phase_nxt = erast_pkg::PH_REG2;
      end
      erast_pkg::ST_R2CHK: begin
        if (sts.y_neg) begin
          state_nxt = erast_pkg::ST_FIN;
        end else begin
          neg_nxt   = sts.d_neg;
          ret_nxt   = 1'b1;
          k_nxt     = 2'd0;
          state_nxt = erast_pkg::ST_EMIT;
        end
      end
      erast_pkg::ST_R2U1: state_nxt = neg_r ? erast_pkg::ST_R2U2 : erast_pkg::ST_R2U3;
      erast_pkg::ST_R2U2: state_nxt = erast_pkg::ST_R2U3;
      erast_pkg::ST_R2U3: state_nxt = erast_pkg::ST_IDLE;
      erast_pkg::ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = erast_pkg::ST_IDLE;
          phase_nxt = erast_pkg::PH_IDLE;
        end
      end
      default: state_nxt = erast_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = erast_pkg::MUL_NONE;
    cmd.acc_op   = erast_pkg::ACC_NONE;
    cmd.slot     = k_r;
    in_tready    = (state_r == erast_pkg::ST_IDLE);
    case (state_r)
      erast_pkg::ST_IDLE: cmd.start = accept && !in_cmd;
      erast_pkg::ST_S1:   cmd.mul_sel = erast_pkg::MUL_RX_RX;
      erast_pkg::ST_S2: begin
        cmd.acc_op  = erast_pkg::ACC_RXSQ;
        cmd.mul_sel = erast_pkg::MUL_RY_RY;
      end
      erast_pkg::ST_S3: begin
        cmd.acc_op  = erast_pkg::ACC_RYSQ;
        cmd.mul_sel = erast_pkg::MUL_RXSQ_Y;
      end
      erast_pkg::ST_S4: cmd.acc_op = erast_pkg::ACC_DINIT;
      erast_pkg::ST_C1: cmd.mul_sel = erast_pkg::MUL_RYSQ_X;
      erast_pkg::ST_C2: begin
        cmd.acc_op  = erast_pkg::ACC_T;
        cmd.mul_sel = erast_pkg::MUL_RXSQ_Y;
      end
      erast_pkg::ST_EMIT: begin
        cmd.out_load = sts.present[k_r] && sts.out_free;
        cmd.out_last = slot_last;
      end
      erast_pkg::ST_U1: cmd.mul_sel = erast_pkg::MUL_RYSQ_2X3;
      erast_pkg::ST_U2: begin
        cmd.acc_op = erast_pkg::ACC_ADD;
        if (neg_r) begin
          cmd.inc_x = 1'b1;
        end else begin
          cmd.mul_sel = erast_pkg::MUL_RXSQ_2Y2;
        end
      end
      erast_pkg::ST_U3: begin
        cmd.acc_op = erast_pkg::ACC_SUB;
        cmd.inc_x  = 1'b1;
        cmd.dec_y  = 1'b1;
      end
      erast_pkg::ST_W1: cmd.mul_sel = erast_pkg::MUL_X_X1;
      erast_pkg::ST_W2: cmd.acc_op  = erast_pkg::ACC_T;
      erast_pkg::ST_W3: cmd.mul_sel = erast_pkg::MUL_RYSQ_T;
      erast_pkg::ST_W4: begin
        cmd.acc_op  = erast_pkg::ACC_LOAD;
        cmd.mul_sel = erast_pkg::MUL_YM_YM;
      end
      erast_pkg::ST_W5: cmd.acc_op  = erast_pkg::ACC_T;
      erast_pkg::ST_W6: cmd.mul_sel = erast_pkg::MUL_RXSQ_T;
      erast_pkg::ST_W7: begin
        cmd.acc_op  = erast_pkg::ACC_ADD;
        cmd.mul_sel = erast_pkg::MUL_RXSQ_RYSQ;
      end
      erast_pkg::ST_W8: cmd.acc_op = erast_pkg::ACC_SUB;
      erast_pkg::ST_R2U1: begin
        cmd.mul_sel = neg_r ? erast_pkg::MUL_RYSQ_2X2 : erast_pkg::MUL_RXSQ_2Y3;
      end
      erast_pkg::ST_R2U2: begin
        cmd.acc_op  = erast_pkg::ACC_ADD;
        cmd.mul_sel = erast_pkg::MUL_RXSQ_2Y3;
      end
      erast_pkg::ST_R2U3: begin
        cmd.acc_op = erast_pkg::ACC_SUB;
        cmd.inc_x  = neg_r;
        cmd.dec_y  = 1'b1;
      end
      erast_pkg::ST_FIN: begin
        cmd.out_load = sts.out_free;
        cmd.out_done = 1'b1;
        cmd.out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= erast_pkg::ST_IDLE;
      phase_r <= erast_pkg::PH_IDLE;
      k_r     <= 2'd0;
      neg_r   <= 1'b0;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      neg_r   <= neg_nxt;
      ret_r   <= ret_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result loaded into a busy output register");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == erast_pkg::ST_FIN && cmd.out_load) |=> (phase_r == erast_pkg::PH_IDLE))
    else $error("finished result without return to idle phase");

  a_emit_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == erast_pkg::ST_EMIT) |-> sts.present[0])
    else $error("first mirrored point missing");

  a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (phase_r == erast_pkg::PH_REG1 && state_r == erast_pkg::ST_S1))
    else $error("start request did not enter region 1 setup");

endmodule

// ===== verif/ellipse_rasterizer_checker.sv =====
// Result checker for the ellipse rasterizer: watches both streams, predicts and compares.
module ellipse_rasterizer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    erast_pkg::kind_t kind;
    logic [15:0]      px;
    logic [15:0]      py;
    logic [15:0]      ex;
    logic             last;
  } raster_out_t;

  raster_out_t pixel_q[$];

  erast_pkg::phase_t ph;
  longint  sx, sy, dec, rxsq, rysq, cx, cy;
  bit      fill;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void push_out(erast_pkg::kind_t k, longint x0, longint y, longint x1);
    raster_out_t r;
    r.kind = k;
    r.px = x0[15:0];
    r.py = y[15:0];
    r.ex = x1[15:0];
    r.last = 1'b0;
    pixel_q.push_back(r);
  endfunction

  function automatic void mirror_point(longint x, longint y);
    if (fill) begin
      push_out(erast_pkg::KIND_SPAN, cx - x, cy - y, cx + x);
      if (y != 0) push_out(erast_pkg::KIND_SPAN, cx - x, cy + y, cx + x);
    end else begin
      push_out(erast_pkg::KIND_PIXEL, cx - x, cy - y, cx - x);
      if (x != 0) push_out(erast_pkg::KIND_PIXEL, cx + x, cy - y, cx + x);
      if (y != 0) begin
        push_out(erast_pkg::KIND_PIXEL, cx - x, cy + y, cx - x);
        if (x != 0) push_out(erast_pkg::KIND_PIXEL, cx + x, cy + y, cx + x);
      end
    end
  endfunction

  function automatic void region2_step();
    if (sy < 0) begin
      ph = erast_pkg::PH_IDLE;
      push_out(erast_pkg::KIND_DONE, 0, 0, 0);
      return;
    end
    mirror_point(sx, sy);
    if (dec < 0) begin
      dec += rysq * (2 * sx + 2) - rxsq * (2 * sy + 3);
      sx++;
    end else begin
      dec -= rxsq * (2 * sy + 3);
    end
    sy--;
  endfunction

  function automatic void predict_request(logic cmd, logic [63:0] d);
    int     base;
    longint rx, ry, ym;
    base = pixel_q.size();
    if (cmd == 1'b0) begin
      rx = longint'(d[43:32]) >> 1;
      ry = longint'(d[55:44]) >> 1;
      rxsq = rx * rx;
      rysq = ry * ry;
      cx = longint'($signed(d[15:0])) + rx;
      cy = longint'($signed(d[31:16])) + ry;
      fill = d[56];
      sx = 0;
      sy = ry;
      dec = rysq - rxsq * ry + rxsq;
      ph = erast_pkg::PH_REG1;
      return;
    end
    if (ph == erast_pkg::PH_REG1) begin
      if (rysq * sx < rxsq * sy) begin
        if (dec < 0) begin
          dec += rysq * (2 * sx + 3);
          if (!fill) mirror_point(sx, sy);
        end else begin
          dec += rysq * (2 * sx + 3) - rxsq * (2 * sy + 2);
          mirror_point(sx, sy);
          sy--;
        end
        sx++;
      end else begin
        ym = sy - 1;
        dec = rysq * (sx * sx + sx) + rxsq * ym * ym - rxsq * rysq;
        ph = erast_pkg::PH_REG2;
        region2_step();
      end
    end else if (ph == erast_pkg::PH_REG2) begin
      region2_step();
    end else begin
      push_out(erast_pkg::KIND_DONE, 0, 0, 0);
    end
    if (pixel_q.size() > base) pixel_q[pixel_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    raster_out_t e;
    if (!rst_n) begin
      ph = erast_pkg::PH_IDLE;
      sx = 0; sy = 0; dec = 0; rxsq = 0; rysq = 0; cx = 0; cy = 0; fill = 0;
      fail_count = 0;
      pixel_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d", out_tuser));
        end else begin
          e = pixel_q.pop_front();
          if (out_tuser !== e.kind)
            report($sformatf("kind %0d, want %0d", out_tuser, e.kind));
          if (out_tdata[15:0] !== e.px)
            report($sformatf("pos_x %0h, want %0h", out_tdata[15:0], e.px));
          if (out_tdata[31:16] !== e.py)
            report($sformatf("pos_y %0h, want %0h", out_tdata[31:16], e.py));
          if (out_tdata[47:32] !== e.ex)
            report($sformatf("span_end_x %0h, want %0h", out_tdata[47:32], e.ex));
          if (out_tlast !== e.last)
            report($sformatf("last %0b, want %0b", out_tlast, e.last));
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
    end
    pending = pixel_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

// ===== verif/tb_ellipse_rasterizer_unit.sv =====
// Stimulus and verdict for the ellipse rasterizer unit.
module tb_ellipse_rasterizer_unit;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 50;
  int          quiet_cycles = 0;

  ellipse_rasterizer_unit DUT (.*);

  ellipse_rasterizer_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold the request until the edge that takes it; tready only changes at rising edges
  task automatic send(input logic cmd, input logic [15:0] left, input logic [15:0] top,
                      input logic [11:0] w, input logic [11:0] h, input logic fm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, fm, h, w, top, left};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic advance();
    send(CMD_ADVANCE, 16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom),
         1'($urandom));
  endtask

  // start a small ellipse and usually run it to completion (plus a few stray advances); now and then stop early
  task automatic run_ellipse(input int max_size);
    int n;
    send(CMD_START, 16'($urandom), 16'($urandom), 12'($urandom_range(max_size)),
         12'($urandom_range(max_size)), 1'($urandom));
    n = ($urandom_range(9) == 0) ? $urandom_range(6) : 2 * max_size + 4;
    repeat (n) advance();
  endtask

  initial begin
    int phase_no;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle advance, point, lines, extremes, restart mid-way
    advance();
    send(CMD_START, 16'h0000, 16'h0000, 12'd0, 12'd0, 1'b0); repeat (3) advance();
    send(CMD_START, 16'h0010, 16'h0010, 12'd9, 12'd1, 1'b0); repeat (8) advance();
    send(CMD_START, 16'h7FFF, 16'h7FFF, 12'd6, 12'd7, 1'b1); repeat (10) advance();
    send(CMD_START, 16'h8000, 16'h8000, 12'hFFF, 12'hFFF, 1'b0); repeat (3) advance();
    send(CMD_START, 16'hFFFF, 16'h0000, 12'd1, 12'd8, 1'b1); repeat (8) advance();

    for (phase_no = 0; phase_no < 3; phase_no++) begin
      send_idle_pct = (phase_no == 0) ? 7 : (phase_no == 1) ? 50 : 0;
      recv_idle_pct = (phase_no == 0) ? 50 : (phase_no == 1) ? 7 : 0;
      repeat (4) run_ellipse(($urandom_range(19) == 0) ? 60 : 12);
    end
    send(CMD_START, 16'($urandom), 16'($urandom), 12'hFFF, 12'hFFE, 1'b1);
    repeat (6) advance();
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/erast_pkg.sv
hw/rtl/erast_dp.sv
hw/rtl/erast_ctrl.sv
hw/rtl/ellipse_rasterizer_unit.sv
verif/ellipse_rasterizer_checker.sv
verif/tb_ellipse_rasterizer_unit.sv
